// File: sv/ssi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssi_pkg;

  // default sizes
  localparam int LIST_DEPTH_DEF = 32;
  localparam int VALUE_BITS_DEF = 32;

  // item kinds
  localparam logic [1:0] KIND_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] KIND_LOAD_SECOND = 2'd1;
  localparam logic [1:0] KIND_RUN         = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
  } ssi_in_t;

  typedef struct packed {
    logic        has_value;
    logic [31:0] common_value;
    logic [5:0]  match_count;
    logic        last;
    logic        overflow;
  } ssi_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } ssi_state_t;

endpackage

`default_nettype wire

// File: sv/ssi_list_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module ssi_list_mem import ssi_pkg::*; #(
  parameter int DEPTH = LIST_DEPTH_DEF,
  parameter int WIDTH = VALUE_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, data appears in the cycle after rd_addr
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: sv/sorted_set_intersection_top.sv
`timescale 1ns / 1ps
`default_nettype none

// load item: busy stays low, so loads can arrive every cycle
// run item: busy through all walk steps and the end step; walk steps <= len1 + len2 - 1, none if a list is empty
//   the merge advances one entry per cycle through the read port of each list memory
// results: each is registered and shown in the cycle
//   after the step that finds the next match (or the end), so at most one per cycle
// reset: list fill counts and drop flag cleared, list contents undefined until loaded

module sorted_set_intersection_top import ssi_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire ssi_in_t  in_item,
  output logic          out_strobe,
  output ssi_out_t      out_item
);

  localparam int IW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  ssi_state_t state_r, state_nxt;

  logic [CW-1:0] cnt_a_r, cnt_a_nxt;
  logic [CW-1:0] cnt_b_r, cnt_b_nxt;
  logic          dropped_r, dropped_nxt;
  logic [CW-1:0] a_r, a_nxt;
  logic [CW-1:0] b_r, b_nxt;
  logic [CW-1:0] found_r, found_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [VALUE_BITS-1:0] pend_val_r, pend_val_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  ssi_out_t      out_item_r, out_item_nxt;

  logic                  we_a, we_b;
  logic [VALUE_BITS-1:0] wr_val;
  logic [VALUE_BITS-1:0] rd_a, rd_b;
  logic                  accept;
  logic                  walk_on;
  logic [VALUE_BITS+31:0] in_wide;
  logic [VALUE_BITS+31:0] pend_wide;

  assign accept = start && !busy;

  // stored values keep VALUE_BITS bits of the id
  assign in_wide   = {{VALUE_BITS{1'b0}}, in_item.value};
  assign wr_val    = in_wide[VALUE_BITS-1:0];
  assign pend_wide = {32'd0, pend_val_r};

  assign we_a = accept && (in_item.kind == KIND_LOAD_FIRST) && (cnt_a_r < DEPTH_C);
  assign we_b = accept && (in_item.kind == KIND_LOAD_SECOND) && (cnt_b_r < DEPTH_C);

  ssi_list_mem #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (VALUE_BITS)
  ) u_first_mem (
    .clk     (clk),
    .wr_en   (we_a),
    .wr_addr (cnt_a_r[IW-1:0]),
    .wr_data (wr_val),
    .rd_addr (a_nxt[IW-1:0]),
    .rd_data (rd_a)
  );

  ssi_list_mem #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (VALUE_BITS)
  ) u_second_mem (
    .clk     (clk),
    .wr_en   (we_b),
    .wr_addr (cnt_b_r[IW-1:0]),
    .wr_data (wr_val),
    .rd_addr (b_nxt[IW-1:0]),
    .rd_data (rd_b)
  );

  // both heads still inside their lists
  assign walk_on = (a_r < cnt_a_r) && (b_r < cnt_b_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_item.kind == KIND_RUN) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!walk_on) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result control
  always_comb begin
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    dropped_nxt    = dropped_r;
    a_nxt          = '0;
    b_nxt          = '0;
    found_nxt      = found_r;
    pend_valid_nxt = pend_valid_r;
    pend_val_nxt   = pend_val_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    busy           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // loads append at the fill count, a full list drops the item
        if (accept) begin
          case (in_item.kind)
            KIND_LOAD_FIRST: begin
              if (cnt_a_r < DEPTH_C) begin
                cnt_a_nxt = cnt_a_r + 1'b1;
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            KIND_LOAD_SECOND: begin
              if (cnt_b_r < DEPTH_C) begin
                cnt_b_nxt = cnt_b_r + 1'b1;
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            KIND_RUN: begin
              found_nxt      = '0;
              pend_valid_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        busy = 1'b1;
        if (walk_on) begin
          // merge step: skip the smaller head, pass both on a match
          if (rd_a < rd_b) begin
            a_nxt = a_r + 1'b1;
            b_nxt = b_r;
          end else if (rd_a > rd_b) begin
            a_nxt = a_r;
            b_nxt = b_r + 1'b1;
          end else begin
            a_nxt = a_r + 1'b1;
            b_nxt = b_r + 1'b1;
            // the previous match is now known not to be the last one
            if (pend_valid_r) begin
              out_strobe_nxt            = 1'b1;
              out_item_nxt.has_value    = 1'b1;
              out_item_nxt.common_value = pend_wide[31:0];
              out_item_nxt.match_count  = 6'(found_r);
              out_item_nxt.last         = 1'b0;
              out_item_nxt.overflow     = dropped_r;
            end
            pend_valid_nxt = 1'b1;
            pend_val_nxt   = rd_a;
            found_nxt      = found_r + 1'b1;
          end
        end else begin
          // end of walk: flush the held match as last, or report empty; empty both lists
          out_strobe_nxt = 1'b1;
          out_item_nxt.last     = 1'b1;
          out_item_nxt.overflow = dropped_r;
          if (pend_valid_r) begin
            out_item_nxt.has_value    = 1'b1;
            out_item_nxt.common_value = pend_wide[31:0];
            out_item_nxt.match_count  = 6'(found_r);
          end else begin
            out_item_nxt.has_value    = 1'b0;
            out_item_nxt.common_value = '0;
            out_item_nxt.match_count  = '0;
          end
          pend_valid_nxt = 1'b0;
          cnt_a_nxt      = '0;
          cnt_b_nxt      = '0;
          dropped_nxt    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      dropped_r    <= 1'b0;
      a_r          <= '0;
      b_r          <= '0;
      found_r      <= '0;
      pend_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      dropped_r    <= dropped_nxt;
      a_r          <= a_nxt;
      b_r          <= b_nxt;
      found_r      <= found_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_val_r <= pend_val_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // a last item is never followed directly by another item
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last |=> !out_strobe)
    else $error("item strobed right after last item");

  // empty report only as the single, final item of a run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.has_value |-> out_item.last && out_item.match_count == '0)
    else $error("empty item not marked last or with nonzero count");

  // fill counts never pass the list depth
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a_r <= DEPTH_C && cnt_b_r <= DEPTH_C)
    else $error("list fill count beyond depth");

  // end of a walk empties both lists and clears the drop flag
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK && !walk_on |=> cnt_a_r == '0 && cnt_b_r == '0 && !dropped_r)
    else $error("lists not emptied after run");

  // every run ends with exactly one last item
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK && !walk_on |=> out_strobe && out_item.last)
    else $error("run ended without last item");

endmodule

`default_nettype wire
